// ===== design/mbhr_pkg.sv =====
// shared types and constants of the modbus holding register server
package mbhr_pkg;
  localparam int unsigned RegWords = 64;
  localparam int unsigned FrameBytes = 256;
  localparam int unsigned MaxRead = 27;
  localparam int unsigned RegAw = $clog2(RegWords);
  localparam int unsigned FrameAw = $clog2(FrameBytes);
  localparam int unsigned CntW = FrameAw + 1;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgPool0Base = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPool0Size = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPool0Ro = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgPool1Base = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPool1Size = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgPool1Ro = 3'd5;

  localparam logic [7:0] FnRead = 8'd3;
  localparam logic [7:0] FnWrSingle = 8'd6;
  localparam logic [7:0] FnWrMulti = 8'd16;
  localparam logic [7:0] ExcFlag = 8'h80;
  localparam logic [7:0] ExcAddr = 8'h02;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } req_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic       reply_end;
  } rsp_t;
endpackage

// ===== design/mbhr_ram.sv =====
// generic single port ram with registered read
module mbhr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== design/modbus_tcp_holding_register_server_core.sv =====
// top level of the modbus tcp holding register server
//
//  channel | signals                          | direction
//  req     | req_valid_i, req_stall_o, req_i  | in, one request byte per transaction
//  rsp     | rsp_valid_o, rsp_stall_i, rsp_o  | out, one response byte per transaction
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i  | in, pool register write
//
// request bytes are taken one per cycle into the frame ram while req_stall_o is low
// after the last byte the first min(count, 12) bytes are read back, one per cycle,
// then the request is decided in StDecide; a single write passes StWrRd and StWrDo
// once, a multiple write once per byte; response header bytes leave one per cycle
// while rsp_stall_i is low; read words pass StRdWait, StRdHi, StRdLo; after reset
// the holding ram is cleared, one word per cycle, no requests taken meanwhile;
// response bytes wait in one output register while rsp_stall_i is high
module modbus_tcp_holding_register_server_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  output logic                         req_stall_o,
  input  mbhr_pkg::req_t               req_i,
  output logic                         rsp_valid_o,
  input  logic                         rsp_stall_i,
  output mbhr_pkg::rsp_t               rsp_o,
  input  logic                         cfg_we_i,
  input  logic [mbhr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [mbhr_pkg::CfgDataW-1:0] cfg_data_i
);
  typedef enum logic [3:0] {
    StClear, StRecv, StHdr, StDecide, StWrRd, StWrDo, StOut, StRdWait, StRdHi, StRdLo
  } state_e;

  state_e state_q;

  // configuration
  logic [15:0] base_q [2];
  logic [6:0]  size_q [2];
  logic        ro_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q[0] <= '0; base_q[1] <= '0;
      size_q[0] <= '0; size_q[1] <= '0;
      ro_q[0] <= 1'b0; ro_q[1] <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mbhr_pkg::CfgPool0Base: base_q[0] <= cfg_data_i;
        mbhr_pkg::CfgPool0Size: size_q[0] <= cfg_data_i[6:0];
        mbhr_pkg::CfgPool0Ro:   ro_q[0] <= cfg_data_i[0];
        mbhr_pkg::CfgPool1Base: base_q[1] <= cfg_data_i;
        mbhr_pkg::CfgPool1Size: size_q[1] <= cfg_data_i[6:0];
        mbhr_pkg::CfgPool1Ro:   ro_q[1] <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // frame ram
  logic                          f_we;
  logic [mbhr_pkg::FrameAw-1:0]  f_addr;
  logic [7:0]                    f_rdata;
  // holding ram
  logic                          h_we;
  logic [mbhr_pkg::RegAw-1:0]    h_addr;
  logic [15:0]                   h_wdata, h_rdata;

  mbhr_ram #(.Width(8), .Depth(mbhr_pkg::FrameBytes)) u_frame (
    .clk_i, .we_i(f_we), .addr_i(f_addr), .wdata_i(req_i.frame_byte), .rdata_o(f_rdata)
  );
  mbhr_ram #(.Width(16), .Depth(mbhr_pkg::RegWords)) u_hold (
    .clk_i, .we_i(h_we), .addr_i(h_addr), .wdata_i(h_wdata), .rdata_o(h_rdata)
  );

  logic [mbhr_pkg::CntW-1:0]    cnt_q;      // frame byte count, saturating
  logic [mbhr_pkg::CntW-1:0]    rp_q;       // frame read pointer (address issued)
  logic [3:0]                   hp_q;       // header byte index of data in f_rdata
  logic                         hv_q;       // f_rdata holds a header byte
  logic [7:0]                   hdr_q [12];
  logic [7:0]                   wh_q;       // write data high byte
  logic [16:0]                  left_q;     // words left to move
  logic [16:0]                  widx_q;     // store word index, may pass RegWords
  logic [mbhr_pkg::RegAw-1:0]   clr_q;
  logic [3:0]                   op_q;       // output byte index in header part
  logic [3:0]                   olen_q;     // header part length
  logic                         kind_rd_q, kind_err_q;
  logic [15:0]                  rword_q;

  logic acc_in, acc_out, out_full;
  assign acc_in  = req_valid_i && !req_stall_o;
  assign acc_out = rsp_valid_o && !rsp_stall_i;
  assign out_full = rsp_valid_o && rsp_stall_i;
  assign req_stall_o = (state_q != StRecv);

  // pool decision on the captured header
  logic [7:0]  fn;
  logic [16:0] a17, n17;
  logic        m_rd [2];
  logic        m_wr [2];
  logic [17:0] wlen;       // bytes a write multiple frame needs
  assign fn  = hdr_q[7];
  assign a17 = {1'b0, hdr_q[8], hdr_q[9]};
  assign n17 = (fn == mbhr_pkg::FnWrSingle) ? 17'd1 : {1'b0, hdr_q[10], hdr_q[11]};
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      m_rd[p] = (a17 >= {1'b0, base_q[p]}) &&
                ({1'b0, a17} + {1'b0, n17} <= {1'b0, base_q[p]} + 18'(size_q[p]));
      m_wr[p] = m_rd[p] && !ro_q[p];
    end
  end
  assign wlen = 18'd13 + {1'b0, n17[15:0], 1'b0};

  logic widx_ok;
  assign widx_ok = (widx_q < 17'(mbhr_pkg::RegWords));

  always_comb begin
    f_we = acc_in && (cnt_q < mbhr_pkg::CntW'(mbhr_pkg::FrameBytes));
    f_addr = f_we ? cnt_q[mbhr_pkg::FrameAw-1:0] : rp_q[mbhr_pkg::FrameAw-1:0];
    h_we = 1'b0;
    h_addr = widx_q[mbhr_pkg::RegAw-1:0];
    h_wdata = {wh_q, f_rdata};
    if (state_q == StClear) begin
      h_we = 1'b1;
      h_addr = clr_q;
      h_wdata = '0;
    end else if (state_q == StWrDo) begin
      h_we = widx_ok && hp_q[0];
    end
  end

  // header byte of the response at position op_q
  logic [7:0]  ob;
  logic [16:0] rl;
  assign rl = 17'd3 + {n17[15:0], 1'b0};
  always_comb begin
    ob = hdr_q[op_q];
    if (kind_err_q) begin
      unique case (op_q)
        4'd4: ob = 8'h00;
        4'd5: ob = 8'h03;
        4'd7: ob = hdr_q[7] | mbhr_pkg::ExcFlag;
        4'd8: ob = mbhr_pkg::ExcAddr;
        default: ;
      endcase
    end else if (kind_rd_q) begin
      unique case (op_q)
        4'd4: ob = rl[15:8];
        4'd5: ob = rl[7:0];
        4'd8: ob = {n17[6:0], 1'b0};
        default: ;
      endcase
    end else begin
      unique case (op_q)
        4'd4: ob = 8'h00;
        4'd5: ob = 8'h06;
        default: ;
      endcase
    end
  end

  logic [7:0] hdr_cnt_clip;
  assign hdr_cnt_clip = (cnt_q < 9'd12) ? 8'(cnt_q) : 8'd12;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
      cnt_q <= '0;
      rp_q <= '0;
      hp_q <= '0;
      hv_q <= 1'b0;
      for (int i = 0; i < 12; i++) hdr_q[i] <= '0;
      wh_q <= '0;
      rword_q <= '0;
      rsp_valid_o <= 1'b0;
      rsp_o <= '0;
      kind_rd_q <= 1'b0;
      kind_err_q <= 1'b0;
      op_q <= '0;
      olen_q <= '0;
      left_q <= '0;
      widx_q <= '0;
    end else begin
      if (acc_out) rsp_valid_o <= 1'b0;
      unique case (state_q)
        StClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == mbhr_pkg::RegAw'(mbhr_pkg::RegWords - 1)) state_q <= StRecv;
        end
        StRecv: begin
          if (acc_in) begin
            if (cnt_q < mbhr_pkg::CntW'(mbhr_pkg::FrameBytes)) cnt_q <= cnt_q + 1'b1;
            if (req_i.frame_end) begin
              state_q <= StHdr;
              rp_q <= '0;
              hp_q <= '0;
              hv_q <= 1'b0;
              for (int i = 0; i < 12; i++) hdr_q[i] <= '0;
            end
          end
        end
        StHdr: begin
          // address rp_q issued this cycle, data arrives next cycle
          if (hv_q) begin
            hdr_q[hp_q] <= f_rdata;
            hp_q <= hp_q + 4'd1;
          end
          if (rp_q < 9'(hdr_cnt_clip)) begin
            rp_q <= rp_q + 1'b1;
            hv_q <= 1'b1;
          end else begin
            hv_q <= 1'b0;
            if (!hv_q) state_q <= StDecide;
          end
        end
        StDecide: begin
          kind_rd_q <= 1'b0;
          kind_err_q <= 1'b0;
          op_q <= '0;
          if (cnt_q < 9'd8 || !(fn == mbhr_pkg::FnRead || fn == mbhr_pkg::FnWrSingle ||
              fn == mbhr_pkg::FnWrMulti)) begin
            cnt_q <= '0;
            state_q <= StRecv;
          end else if (cnt_q < 9'd12) begin
            kind_err_q <= 1'b1; olen_q <= 4'd9; state_q <= StOut;
          end else if (fn == mbhr_pkg::FnRead) begin
            olen_q <= 4'd9;
            left_q <= n17;
            if (n17 > 17'(mbhr_pkg::MaxRead) || !(m_rd[0] || m_rd[1])) begin
              kind_err_q <= 1'b1;
            end else begin
              kind_rd_q <= 1'b1;
              widx_q <= m_rd[0] ? a17 - {1'b0, base_q[0]}
                                : 17'(size_q[0]) + a17 - {1'b0, base_q[1]};
            end
            state_q <= StOut;
          end else if (fn == mbhr_pkg::FnWrMulti && {9'd0, cnt_q} < wlen) begin
            kind_err_q <= 1'b1; olen_q <= 4'd9; state_q <= StOut;
          end else if (!(m_wr[0] || m_wr[1])) begin
            kind_err_q <= 1'b1; olen_q <= 4'd9; state_q <= StOut;
          end else begin
            olen_q <= 4'd12;
            widx_q <= m_wr[0] ? a17 - {1'b0, base_q[0]}
                              : 17'(size_q[0]) + a17 - {1'b0, base_q[1]};
            if (fn == mbhr_pkg::FnWrSingle) begin
              // single write: high byte from the header, low byte re-read from byte 11
              wh_q <= hdr_q[10];
              left_q <= 17'd0;
              hp_q <= 4'd1;
              rp_q <= 9'd11;
              state_q <= StWrRd;
            end else begin
              left_q <= n17;
              rp_q <= 9'd13;
              hp_q <= 4'd0;
              state_q <= StWrRd;
            end
          end
        end
        StWrRd: begin
          // issue read of rp_q; data next cycle in StWrDo
          if (fn == mbhr_pkg::FnWrSingle) begin
            state_q <= StWrDo;
          end else if (left_q == 17'd0) begin
            state_q <= StOut;
          end else begin
            rp_q <= rp_q + 1'b1;
            state_q <= StWrDo;
          end
        end
        StWrDo: begin
          if (fn == mbhr_pkg::FnWrSingle) begin
            state_q <= StOut;
          end else if (!hp_q[0]) begin
            wh_q <= f_rdata;
            hp_q <= 4'd1;
            state_q <= StWrRd;
          end else begin
            hp_q <= 4'd0;
            widx_q <= widx_q + 17'd1;
            left_q <= left_q - 17'd1;
            state_q <= StWrRd;
          end
        end
        StOut: begin
          if (!out_full) begin
            rsp_valid_o <= 1'b1;
            rsp_o.reply_byte <= ob;
            rsp_o.reply_end <= (op_q == olen_q - 4'd1) && !(kind_rd_q && left_q != 17'd0);
            op_q <= op_q + 4'd1;
            if (op_q == olen_q - 4'd1) begin
              if (kind_rd_q && left_q != 17'd0) begin
                state_q <= StRdWait;
              end else begin
                cnt_q <= '0;
                state_q <= StRecv;
              end
            end
          end
        end
        StRdWait: begin
          state_q <= StRdHi;
        end
        StRdHi: begin
          if (!out_full) begin
            rword_q <= widx_ok ? h_rdata : 16'd0;
            rsp_valid_o <= 1'b1;
            rsp_o.reply_byte <= widx_ok ? h_rdata[15:8] : 8'd0;
            rsp_o.reply_end <= 1'b0;
            state_q <= StRdLo;
          end
        end
        StRdLo: begin
          if (!out_full) begin
            rsp_valid_o <= 1'b1;
            rsp_o.reply_byte <= rword_q[7:0];
            rsp_o.reply_end <= (left_q == 17'd1);
            left_q <= left_q - 17'd1;
            widx_q <= widx_q + 17'd1;
            if (left_q == 17'd1) begin
              cnt_q <= '0;
              state_q <= StRecv;
            end else begin
              state_q <= StRdWait;
            end
          end
        end
        default: state_q <= StClear;
      endcase
    end
  end

  // no store write while bytes are being received
  assert property (@(posedge clk_i) disable iff (!rst_ni) f_we |-> !h_we)
    else $error("store write during receive");
  // response only leaves while serving
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_o) |-> $past(state_q) != StRecv)
    else $error("response while receiving");
  // count never exceeds the frame buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= mbhr_pkg::CntW'(mbhr_pkg::FrameBytes))
    else $error("frame count overflow");
endmodule
